// ----- rtl/core/h264_nal_unit_splitter_assert.svh -----
// Assertion macros for the NAL unit splitter
`ifndef H264_NAL_UNIT_SPLITTER_ASSERT_SVH
`define H264_NAL_UNIT_SPLITTER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define H264NAL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define H264NAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/h264nal_pkg.sv -----
// Shared types and constants for the NAL unit splitter
`timescale 1ns / 1ps
`default_nettype none

package h264nal_pkg;

    localparam int unsigned LEN_W      = 20;
    localparam int unsigned WIN_TAPS   = 4;   // stored bytes; the fifth is the incoming one

    localparam logic [7:0] HDR_SPS     = 8'h67;
    localparam logic [7:0] HDR_PPS     = 8'h68;
    localparam logic [7:0] SC_LAST     = 8'h01;
    localparam logic [7:0] SC_ZERO     = 8'h00;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 20'd307200;

    // positions skipped after a start code, so its own tail is not seen again
    localparam logic [1:0] SKIP_SC3    = 2'd2;
    localparam logic [1:0] SKIP_SC4    = 2'd3;

    // one classified window position, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       found;
        logic       hdr_param;
    } t_scan_entry;

endpackage

`default_nettype wire

// ----- rtl/core/h264_nal_unit_splitter.sv -----
// Top level of the H.264 Annex B NAL unit splitter
//
//  channel   dir  handshake                   payload
//  input     in   i_in_valid / o_in_ready     i_stream_byte
//  output    out  o_out_valid / i_out_ready   o_unit_byte, o_unit_start,
//                                             o_unit_abort, o_param_unit
//  config    in   i_cfg_we (no wait)          i_cfg_wdata (max_unit_len)
//
// One byte per cycle unless the output stalls; the front classifies a window
// position in the cycle of the transfer, the back resolves it out of the queue.
// The first four bytes after reset only fill the window and give no result.
// Reset is synchronous, active low; it empties window, queue and output stage.
// Output stalls back up through the P_QUEUE_DEPTH-entry queue to o_in_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "h264_nal_unit_splitter_assert.svh"

module h264_nal_unit_splitter
    import h264nal_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = 4
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_stream_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_unit_byte,
    output logic                   o_unit_start,
    output logic                   o_unit_abort,
    output logic                   o_param_unit,
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_wdata
);

    logic [LEN_W-1:0]  r_max_len;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_valid;
    t_scan_entry       front_entry;
    t_scan_entry       back_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    h264nal_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (front_entry)
    );

    h264nal_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    h264nal_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_entry      (back_entry),
        .o_pop        (q_pop),
        .i_max_len    (r_max_len),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_unit_byte  (o_unit_byte),
        .o_unit_start (o_unit_start),
        .o_unit_abort (o_unit_abort),
        .o_param_unit (o_param_unit)
    );

    `H264NAL_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, q_push && q_full, q_pop, "queue overflow")
    `H264NAL_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, q_pop, q_valid, "queue underflow")
    `H264NAL_ASSERT_IMPL(a_abort_void, i_clk, i_rst_n, o_out_valid && o_unit_abort, (o_unit_byte == 8'h00) && !o_unit_start, "abort carries a byte")
    `H264NAL_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !o_out_valid && !q_valid, "not idle after reset")

endmodule

`default_nettype wire

// ----- rtl/core/h264nal_front.sv -----
// Front end: lookahead window and start code classification
`timescale 1ns / 1ps
`default_nettype none

module h264nal_front
    import h264nal_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_stream_byte,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_scan_entry      o_entry
);

    logic [2:0]  r_fill;
    logic [2:0]  n_fill;
    logic [1:0]  r_skip;
    logic [1:0]  n_skip;
    logic [7:0]  r_win [WIN_TAPS];

    logic        window_full;
    logic        accept;
    logic        sc3;
    logic        sc4;
    logic [7:0]  hdr;
    logic        found;

    assign window_full = (r_fill == 3'(WIN_TAPS));
    assign o_in_ready  = !window_full || !i_q_full;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept && window_full;

    assign sc4 = (r_win[0] == SC_ZERO) && (r_win[1] == SC_ZERO) &&
                 (r_win[2] == SC_ZERO) && (r_win[3] == SC_LAST);
    assign sc3 = (r_win[0] == SC_ZERO) && (r_win[1] == SC_ZERO) &&
                 (r_win[2] == SC_LAST);
    assign hdr   = sc4 ? i_stream_byte : r_win[3];
    assign found = (sc3 || sc4) && (r_skip == 2'd0);

    assign o_entry = '{data:      r_win[0],
                       found:     found,
                       hdr_param: (hdr == HDR_SPS) || (hdr == HDR_PPS)};

    always_comb begin
        n_fill = r_fill;
        n_skip = r_skip;
        if (accept && !window_full) begin
            n_fill = r_fill + 3'd1;
        end
        if (o_push) begin
            if (found) begin
                n_skip = sc4 ? SKIP_SC4 : SKIP_SC3;
            end else if (r_skip != 2'd0) begin
                n_skip = r_skip - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_skip <= '0;
        end else begin
            r_fill <= n_fill;
            r_skip <= n_skip;
        end
    end

    // window bytes are always written before they are looked at
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!window_full) begin
                r_win[r_fill[1:0]] <= i_stream_byte;
            end else begin
                for (int i = 0; i < WIN_TAPS - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN_TAPS-1] <= i_stream_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/h264nal_queue.sv -----
// Short FIFO of classified window positions between front and back
`timescale 1ns / 1ps
`default_nettype none

module h264nal_queue
    import h264nal_pkg::*;
#(
    parameter int unsigned P_DEPTH = 4
)
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_scan_entry   i_entry,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output t_scan_entry        o_entry
);

    localparam int unsigned PTR_W = $clog2(P_DEPTH);
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);

    t_scan_entry        r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/h264nal_back.sv -----
// Back end: unit state machine, length limit and output register
`timescale 1ns / 1ps
`default_nettype none

module h264nal_back
    import h264nal_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_scan_entry       i_entry,
    output logic                   o_pop,
    input  wire logic [LEN_W-1:0]  i_max_len,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_unit_byte,
    output logic                   o_unit_start,
    output logic                   o_unit_abort,
    output logic                   o_param_unit
);

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_PLAIN,
        MODE_PARAM_WAIT,
        MODE_PARAM_SEEN
    } t_mode;

    t_mode              r_mode;
    t_mode              n_mode;
    t_mode              cont_mode;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [7:0]         r_byte;
    logic [7:0]         n_byte;
    logic               r_start;
    logic               n_start;
    logic               r_abort;
    logic               n_abort;
    logic               r_param;
    logic               n_param;
    logic               new_unit;

    assign o_pop        = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_unit_byte  = r_byte;
    assign o_unit_start = r_start;
    assign o_unit_abort = r_abort;
    assign o_param_unit = r_param;

    // a start code inside a waiting parameter unit is absorbed into it
    assign new_unit  = i_entry.found && (r_mode != MODE_PARAM_WAIT);
    assign cont_mode = (i_entry.found && !i_entry.hdr_param) ? MODE_PARAM_SEEN : r_mode;

    always_comb begin
        n_mode      = r_mode;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_out_ready;
        n_byte      = r_byte;
        n_start     = r_start;
        n_abort     = r_abort;
        n_param     = r_param;
        if (o_pop) begin
            if (new_unit) begin
                n_mode      = i_entry.hdr_param ? MODE_PARAM_WAIT : MODE_PLAIN;
                n_len       = LEN_W'(1);
                n_out_valid = 1'b1;
                n_byte      = i_entry.data;
                n_start     = 1'b1;
                n_abort     = 1'b0;
                n_param     = i_entry.hdr_param;
            end else begin
                n_mode = cont_mode;
                if (cont_mode != MODE_HUNT) begin
                    n_out_valid = 1'b1;
                    n_start     = 1'b0;
                    n_param     = (cont_mode == MODE_PARAM_WAIT) ||
                                  (cont_mode == MODE_PARAM_SEEN);
                    if (r_len >= i_max_len) begin
                        n_mode  = MODE_HUNT;
                        n_len   = '0;
                        n_byte  = 8'h00;
                        n_abort = 1'b1;
                    end else begin
                        n_len   = r_len + LEN_W'(1);
                        n_byte  = i_entry.data;
                        n_abort = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HUNT;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_byte  <= n_byte;
        r_start <= n_start;
        r_abort <= n_abort;
        r_param <= n_param;
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the H.264 Annex B NAL unit splitter
`timescale 1ns / 1ps

module testbench;
    import h264nal_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned PHASE_BYTES  = 312;
    localparam int unsigned SHOWN_ERRORS = 40;

    localparam logic [7:0] NAL_IDR   = 8'h65;
    localparam logic [7:0] NAL_SLICE = 8'h41;
    localparam logic [7:0] NAL_SEI   = 8'h06;

    typedef enum logic [1:0] {
        HUNTING       = 2'd0,
        PLAIN_UNIT    = 2'd1,
        PARAM_WAITING = 2'd2,
        PARAM_SEEN    = 2'd3
    } t_split_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       voided;
        logic       param;
    } t_unit_out;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       stream_byte = 8'h00;
    logic             o_out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       o_unit_byte;
    logic             o_unit_start;
    logic             o_unit_abort;
    logic             o_param_unit;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    h264_nal_unit_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (stream_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_unit_byte   (o_unit_byte),
        .o_unit_start  (o_unit_start),
        .o_unit_abort  (o_unit_abort),
        .o_param_unit  (o_param_unit),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    // stimulus and expectations
    logic [7:0]  pending_bytes [$];
    t_unit_out   expected_units [$];
    t_unit_out   predicted;
    bit          bursts_on = 1'b1;

    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned units_checked = 0;
    int unsigned starts_seen = 0;
    int unsigned aborts_seen = 0;
    int unsigned param_seen = 0;
    int unsigned limit_writes = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    // splitter state as predicted
    logic [7:0]       win [0:4];
    int unsigned      win_fill;
    t_split_mode      mode;
    logic [2:0]       skip_left;
    logic [LEN_W-1:0] seg_len;
    logic [LEN_W-1:0] len_limit;

    logic [LEN_W-1:0] phase_limits [0:5];

    // junk, SPS, absorbed PPS and IDR, over-limit abort at 16, slice, trailing zeros
    logic [7:0] opening_bytes [0:24] = '{
        8'hFF, 8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01,
        8'h68, 8'hBB, 8'h00, 8'h00, 8'h01, 8'h65, 8'h80, 8'h7F, 8'h00, 8'h00,
        8'h01, 8'h41, 8'h55, 8'h00, 8'h00
    };

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_splitter();
        for (int i = 0; i < 5; i++) win[i] = 8'h00;
        win_fill  = 0;
        mode      = HUNTING;
        skip_left = '0;
        seg_len   = '0;
        len_limit = MAX_LEN_RESET;
    endfunction

    function automatic bit is_param_hdr(input logic [7:0] h);
        return h == HDR_SPS || h == HDR_PPS;
    endfunction

    // one stream byte in; returns 1 with the unit byte it releases, if any
    function automatic bit split_byte(input logic [7:0] b, output t_unit_out res);
        logic [7:0] oldest;
        logic       sc3, sc4, found, hdr_param;
        logic [2:0] skip_next;
        bit         produced;
        produced = 1'b0;
        res = '0;
        if (win_fill > 4) win_fill = 4;
        win[win_fill] = b;
        win_fill++;
        if (win_fill < 5) return 1'b0;

        oldest = win[0];
        sc4 = win[0] == SC_ZERO && win[1] == SC_ZERO && win[2] == SC_ZERO && win[3] == SC_LAST;
        sc3 = win[0] == SC_ZERO && win[1] == SC_ZERO && win[2] == SC_LAST;
        hdr_param = is_param_hdr(sc4 ? win[4] : win[3]);
        skip_next = sc4 ? {1'b0, SKIP_SC4} : {1'b0, SKIP_SC3};
        found = (sc3 || sc4) && skip_left == 0;
        if (skip_left != 0) skip_left--;

        if (found && mode == PARAM_WAITING) begin
            if (!hdr_param) mode = PARAM_SEEN;
            skip_left = skip_next;
            found = 1'b0;
        end else if (found) begin
            mode = hdr_param ? PARAM_WAITING : PLAIN_UNIT;
            skip_left = skip_next;
            seg_len = 1;
            res = '{data: oldest, start: 1'b1, voided: 1'b0, param: hdr_param};
            produced = 1'b1;
        end

        if (!found && mode != HUNTING && !produced) begin
            if (seg_len >= len_limit) begin
                res = '{data: 8'h00, start: 1'b0, voided: 1'b1,
                        param: mode == PARAM_WAITING || mode == PARAM_SEEN};
                mode = HUNTING;
                seg_len = '0;
            end else begin
                seg_len = seg_len + 1'b1;
                res = '{data: oldest, start: 1'b0, voided: 1'b0,
                        param: mode == PARAM_WAITING || mode == PARAM_SEEN};
            end
            produced = 1'b1;
        end

        for (int i = 0; i < 4; i++) win[i] = win[i + 1];
        win[4] = 8'h00;
        win_fill = 4;
        return produced;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < SHOWN_ERRORS) $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_unit();
        t_unit_out want;
        if (expected_units.size() == 0) begin
            report_error($sformatf("output with none expected: byte %02h start %0b abort %0b param %0b",
                                   o_unit_byte, o_unit_start, o_unit_abort, o_param_unit));
            return;
        end
        want = expected_units.pop_front();
        if (o_unit_byte !== want.data)
            report_error($sformatf("unit_byte %02h, expected %02h", o_unit_byte, want.data));
        if (o_unit_start !== want.start)
            report_error($sformatf("unit_start %0b, expected %0b", o_unit_start, want.start));
        if (o_unit_abort !== want.voided)
            report_error($sformatf("unit_abort %0b, expected %0b", o_unit_abort, want.voided));
        if (o_param_unit !== want.param)
            report_error($sformatf("param_unit %0b, expected %0b", o_param_unit, want.param));
        units_checked++;
        if (want.start) starts_seen++;
        if (want.voided) aborts_seen++;
        if (want.param) param_seen++;
    endtask

    // driver: feeds pending bytes, predicts on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid    <= 1'b0;
            stream_byte <= 8'h00;
            send_gap    = 0;
            clear_splitter();
        end else begin
            if (in_valid && o_in_ready) begin
                bytes_sent++;
                if (split_byte(stream_byte, predicted)) expected_units.push_back(predicted);
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap == 0 && bursts_on && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 10);
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    in_valid    <= 1'b1;
                    stream_byte <= pending_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, checks every output transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) check_unit();
            if (stall_left == 0 && bursts_on && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_limit(input logic [LEN_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        len_limit = value;
        limit_writes++;
    endtask

    // block idle: all bytes sent, all outputs back, then let the pipeline empty
    task automatic settle();
        while (pending_bytes.size() != 0 || in_valid || expected_units.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // well-formed NAL units with random content, plus some noise and broken start codes
    task automatic queue_stream(input int unsigned budget);
        int unsigned base;
        int unsigned roll;
        int unsigned body;
        logic [7:0]  hdr;
        base = pending_bytes.size();
        while (pending_bytes.size() - base < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 6))
                    pending_bytes.push_back($urandom_range(0, 3) == 0 ?
                                            8'($urandom_range(0, 255)) :
                                            8'($urandom_range(0, 1)));
            end else if (roll < 12) begin
                pending_bytes.push_back(SC_ZERO);
                if ($urandom_range(0, 1)) pending_bytes.push_back(SC_ZERO);
                pending_bytes.push_back(8'($urandom_range(2, 255)));
            end else begin
                if ($urandom_range(0, 1)) pending_bytes.push_back(SC_ZERO);
                pending_bytes.push_back(SC_ZERO);
                pending_bytes.push_back(SC_ZERO);
                pending_bytes.push_back(SC_LAST);
                case ($urandom_range(0, 9))
                    0, 1:    hdr = HDR_SPS;
                    2, 3:    hdr = HDR_PPS;
                    4:       hdr = NAL_IDR;
                    5:       hdr = NAL_SLICE;
                    6:       hdr = NAL_SEI;
                    default: hdr = 8'($urandom_range(0, 255));
                endcase
                pending_bytes.push_back(hdr);
                body = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 24);
                repeat (body) pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(20'd16);
        foreach (opening_bytes[i]) pending_bytes.push_back(opening_bytes[i]);
        settle();

        phase_limits[0] = 20'hFFFFF;
        phase_limits[1] = 20'd16;
        phase_limits[2] = MAX_LEN_RESET;
        phase_limits[3] = 20'($urandom_range(17, 48));
        phase_limits[4] = 20'($urandom_range(16, 20'hFFFFF));
        phase_limits[5] = 20'd24;

        for (int p = 0; p < 6; p++) begin
            write_limit(phase_limits[p]);
            if (p == 5) bursts_on = 1'b0;
            queue_stream(PHASE_BYTES);
            settle();
        end

        $display("Fed %0d stream bytes under %0d length limits (16 to 1048575).",
                 bytes_sent, limit_writes);
        $display("Checked %0d outputs: %0d unit starts, %0d aborts, %0d in parameter units.",
                 units_checked, starts_seen, aborts_seen, param_seen);
        if (error_count == 0 && expected_units.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d outputs outstanding",
                 cycle_count, expected_units.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- h264_nal_unit_splitter.f -----
+incdir+rtl/core
rtl/core/h264nal_pkg.sv
rtl/core/h264nal_front.sv
rtl/core/h264nal_queue.sv
rtl/core/h264nal_back.sv
rtl/core/h264_nal_unit_splitter.sv
test/testbench.sv
